// File: sv/ofn_pkg.sv
// Shared constants and types for the orthonormal frame pipeline.
// No dependencies; used by ofn_unit and orthonormal_frame_from_normal.
package ofn_pkg;

  // Width the vector magnitudes are aligned to before squaring.
  localparam int MAG_W    = 31;
  // Sum of three squares and the integer square root.
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int RT_STEPS = 32;
  // Partial remainder widths of the root and divide steps.
  localparam int RREM_W   = ROOT_W + 2;
  localparam int DREM_W   = ROOT_W + 2;

  // Status that travels with a normalized vector.
  typedef struct packed {
    logic       zero;  // vector had zero length
    logic [2:0] neg;   // per-component sign
  } unit_flags_t;

  // Coordinate axis chosen for the first cross product.
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

endpackage

// File: sv/ofn_in_if.sv
// Input channel: one normal vector per beat, valid/ready handshake.
// Depends on nothing.
interface ofn_in_if #(
  parameter int COMPONENT_WIDTH = 16
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] normal_x;
  logic signed [COMPONENT_WIDTH-1:0] normal_y;
  logic signed [COMPONENT_WIDTH-1:0] normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// File: sv/ofn_out_if.sv
// Output channel: one frame (three axes and two flags) per beat.
// Depends on nothing.
interface ofn_out_if #(
  parameter int COMPONENT_WIDTH = 16
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] xaxis_x;
  logic signed [COMPONENT_WIDTH-1:0] xaxis_y;
  logic signed [COMPONENT_WIDTH-1:0] xaxis_z;
  logic signed [COMPONENT_WIDTH-1:0] yaxis_x;
  logic signed [COMPONENT_WIDTH-1:0] yaxis_y;
  logic signed [COMPONENT_WIDTH-1:0] yaxis_z;
  logic signed [COMPONENT_WIDTH-1:0] zaxis_x;
  logic signed [COMPONENT_WIDTH-1:0] zaxis_y;
  logic signed [COMPONENT_WIDTH-1:0] zaxis_z;
  logic                              axes_swapped;
  logic                              degenerate;

  modport source (output valid, xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
                  zaxis_x, zaxis_y, zaxis_z, axes_swapped, degenerate, input ready);
  modport sink (input valid, xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
                zaxis_x, zaxis_y, zaxis_z, axes_swapped, degenerate, output ready);
endinterface

// File: sv/ofn_unit.sv
// Pipelined vector normalizer: align, sum of squares, 32-step square root,
// one-bit-per-stage rounding divide. Depends on ofn_pkg.
module ofn_unit #(
  parameter int VW    = 17,
  parameter int FB    = 14,
  parameter int SIDEW = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [2:0][VW-1:0]        vec_i,
  input  logic [SIDEW-1:0]          side_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [2:0][FB:0]          quo_o,
  output ofn_pkg::unit_flags_t      flags_o,
  output logic [SIDEW-1:0]          side_o
);

  localparam int AW     = ofn_pkg::MAG_W;
  localparam int SQW    = 2 * AW;
  localparam int SW     = $clog2(VW + 1);
  localparam int DSTEPS = FB + 1;
  localparam int NW     = AW + FB + 2;
  localparam int TW     = SIDEW + 3;
  localparam int S_MAG  = 0;
  localparam int S_SHF  = 1;
  localparam int S_ALN  = 2;
  localparam int S_SQR  = 3;
  localparam int S_SUM  = 4;
  localparam int S_RT0  = 5;
  localparam int S_DV0  = S_RT0 + ofn_pkg::RT_STEPS;
  localparam int NST    = S_DV0 + DSTEPS + 1;

  // ---- valid bits and stall chain
  logic [NST-1:0] v_q;
  logic [NST:0]   adv;
  logic [NST:0]   vin;

  assign adv[NST] = ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign vin = {v_q, valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= vin[k+1-1];
        end
      end
    end
  end

  // ---- sideband and signs travel along every stage
  logic [TW-1:0] tag_q [NST];
  logic [TW-1:0] tag_c [NST+1];
  logic [2:0]    neg_w;

  for (genvar i = 0; i < 3; i++) begin : g_neg
    assign neg_w[i] = vec_i[i][VW-1];
  end
  assign tag_c[0] = {side_i, neg_w};
  for (genvar k = 0; k < NST; k++) begin : g_tagc
    assign tag_c[k+1] = tag_q[k];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) begin
        tag_q[k] <= tag_c[k];
      end
    end
  end

  // ---- stage: magnitudes and their maximum
  logic [2:0][VW-1:0] mag_w, mag0_q, mag1_q;
  logic [VW-1:0]      mx_w, mx0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = vec_i[i][VW-1] ? (~vec_i[i] + VW'(1)) : vec_i[i];
    end
    mx_w = mag_w[0];
    if (mag_w[1] > mx_w) mx_w = mag_w[1];
    if (mag_w[2] > mx_w) mx_w = mag_w[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_MAG]) begin
      mag0_q <= mag_w;
      mx0_q  <= mx_w;
    end
  end

  // ---- stage: shift that brings the maximum below 2^AW
  logic [SW-1:0] bl_w, s_w, s1_q;

  always_comb begin
    bl_w = '0;
    for (int i = 0; i < VW; i++) begin
      if (mx0_q[i]) bl_w = SW'(i + 1);
    end
    s_w = (int'(bl_w) > AW) ? SW'(int'(bl_w) - AW) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_SHF]) begin
      mag1_q <= mag0_q;
      s1_q   <= s_w;
    end
  end

  // ---- stages: align, square, sum
  logic [2:0][AW-1:0]  a2_q, a3_q, a4_q;
  logic [2:0][SQW-1:0] sq3_q;
  logic [ofn_pkg::SUM_W-1:0] sum4_q;

  always_ff @(posedge clk_i) begin
    if (adv[S_ALN]) begin
      for (int i = 0; i < 3; i++) begin
        a2_q[i] <= AW'(mag1_q[i] >> s1_q);
      end
    end
    if (adv[S_SQR]) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= SQW'(a2_q[i]) * SQW'(a2_q[i]);
      end
      a3_q <= a2_q;
    end
    if (adv[S_SUM]) begin
      sum4_q <= ofn_pkg::SUM_W'(sq3_q[0]) + ofn_pkg::SUM_W'(sq3_q[1])
              + ofn_pkg::SUM_W'(sq3_q[2]);
      a4_q   <= a3_q;
    end
  end

  // ---- square root: one result bit per stage
  logic [ofn_pkg::SUM_W-1:0]  rt_acc_q  [ofn_pkg::RT_STEPS];
  logic [ofn_pkg::RREM_W-1:0] rt_rem_q  [ofn_pkg::RT_STEPS];
  logic [ofn_pkg::ROOT_W-1:0] rt_root_q [ofn_pkg::RT_STEPS];
  logic [2:0][AW-1:0]         rt_a_q    [ofn_pkg::RT_STEPS];
  logic [ofn_pkg::SUM_W-1:0]  rt_acc_c  [ofn_pkg::RT_STEPS+1];
  logic [ofn_pkg::RREM_W-1:0] rt_rem_c  [ofn_pkg::RT_STEPS+1];
  logic [ofn_pkg::ROOT_W-1:0] rt_root_c [ofn_pkg::RT_STEPS+1];
  logic [2:0][AW-1:0]         rt_a_c    [ofn_pkg::RT_STEPS+1];

  assign rt_acc_c[0]  = sum4_q;
  assign rt_rem_c[0]  = '0;
  assign rt_root_c[0] = '0;
  assign rt_a_c[0]    = a4_q;

  for (genvar k = 0; k < ofn_pkg::RT_STEPS; k++) begin : g_rt
    logic [ofn_pkg::RREM_W-1:0] remn, trial;
    logic                       ge;

    assign remn  = {rt_rem_c[k][ofn_pkg::RREM_W-3:0],
                    rt_acc_c[k][ofn_pkg::SUM_W-1 -: 2]};
    assign trial = {rt_root_c[k], 2'b01};
    assign ge    = remn >= trial;

    always_ff @(posedge clk_i) begin
      if (adv[S_RT0+k]) begin
        rt_acc_q[k]  <= {rt_acc_c[k][ofn_pkg::SUM_W-3:0], 2'b00};
        rt_rem_q[k]  <= ge ? remn - trial : remn;
        rt_root_q[k] <= {rt_root_c[k][ofn_pkg::ROOT_W-2:0], ge};
        rt_a_q[k]    <= rt_a_c[k];
      end
    end

    assign rt_acc_c[k+1]  = rt_acc_q[k];
    assign rt_rem_c[k+1]  = rt_rem_q[k];
    assign rt_root_c[k+1] = rt_root_q[k];
    assign rt_a_c[k+1]    = rt_a_q[k];
  end

  // ---- rounding divide: round(a * 2^FB / len) = (a*2^(FB+1) + len) / (2*len)
  logic [2:0][ofn_pkg::DREM_W-1:0] dv_rem_q [DSTEPS+1];
  logic [2:0][FB:0]                dv_low_q [DSTEPS+1];
  logic [2:0][FB:0]                dv_quo_q [DSTEPS+1];
  logic [ofn_pkg::DREM_W-1:0]      dv_d_q   [DSTEPS+1];
  logic                            dv_z_q   [DSTEPS+1];
  logic [ofn_pkg::ROOT_W-1:0]      len_w;
  logic [2:0][NW-1:0]              num_w;

  assign len_w = rt_root_c[ofn_pkg::RT_STEPS];
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign num_w[i] = NW'({rt_a_c[ofn_pkg::RT_STEPS][i], (FB + 1)'(0)}) + NW'(len_w);
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_DV0]) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= ofn_pkg::DREM_W'(num_w[i][NW-1:FB+1]);
        dv_low_q[0][i] <= num_w[i][FB:0];
      end
      dv_quo_q[0] <= '0;
      dv_d_q[0]   <= ofn_pkg::DREM_W'({len_w, 1'b0});
      dv_z_q[0]   <= (len_w == '0);
    end
  end

  for (genvar j = 1; j <= DSTEPS; j++) begin : g_dv
    logic [2:0][ofn_pkg::DREM_W-1:0] remn, remd;
    logic [2:0]                      ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        remn[i] = {dv_rem_q[j-1][i][ofn_pkg::DREM_W-2:0], dv_low_q[j-1][i][FB]};
        ge[i]   = remn[i] >= dv_d_q[j-1];
        remd[i] = ge[i] ? remn[i] - dv_d_q[j-1] : remn[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[S_DV0+j]) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j][i] <= remd[i];
          dv_low_q[j][i] <= {dv_low_q[j-1][i][FB-1:0], 1'b0};
          dv_quo_q[j][i] <= {dv_quo_q[j-1][i][FB-1:0], ge[i]};
        end
        dv_d_q[j] <= dv_d_q[j-1];
        dv_z_q[j] <= dv_z_q[j-1];
      end
    end
  end

  // ---- outputs
  assign ready_o       = adv[0];
  assign valid_o       = v_q[NST-1];
  assign quo_o         = dv_quo_q[DSTEPS];
  assign flags_o.zero  = dv_z_q[DSTEPS];
  assign flags_o.neg   = tag_q[NST-1][2:0];
  assign side_o        = tag_q[NST-1][TW-1:3];

  // ---- checks
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !flags_o.zero |->
      (quo_o[0] <= (FB + 1)'(1 << FB)) && (quo_o[1] <= (FB + 1)'(1 << FB)) &&
      (quo_o[2] <= (FB + 1)'(1 << FB)))
    else $error("normalized component above one");

  a_quo_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !flags_o.zero |-> (quo_o[0] != '0) || (quo_o[1] != '0) || (quo_o[2] != '0))
    else $error("nonzero vector normalized to zero");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> v_q[0] && !ready_i)
    else $error("input stalled with a free first stage");

endmodule

// File: sv/orthonormal_frame_from_normal.sv
// Top level: orthonormal frame (x, y, z axes) from one normal per beat.
// Depends on ofn_pkg, ofn_in_if, ofn_out_if and ofn_unit.
//
// Usage
//   norm_i carries one normal (three signed components, COMPONENT_WIDTH-2
//   fraction bits) per beat; frame_o returns one frame per beat, in order.
//   z axis = the normal as given; y = unit(n x a) with a the coordinate axis
//   where |n| is smallest (ties to x, then y); x = unit(y x n).
//   A zero-length cross product zeroes both axes and raises degenerate;
//   axes_swapped is raised whenever x.(y x n) is not positive.
// Throughput
//   One beat per cycle while frame_o does not stall: every stage is registered,
//   the two normalizers are a 32-step root pipeline plus a one-bit-per-stage
//   divider.
// Reset and stalls
//   Reset clears all valid bits only; the data registers are not reset.
//   A stalled frame_o holds its beat; the pipeline keeps accepting until every
//   stage is occupied (bubbles are squeezed out), then norm_i.ready drops.
module orthonormal_frame_from_normal #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ofn_in_if.sink    norm_i,
  ofn_out_if.source frame_o
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int F   = W - 2;
  localparam int VW1 = W + 1;
  localparam int VW2 = 2 * W;
  localparam int SD1 = 3 * W;
  localparam int SD2 = 6 * W + 1;

  // ---- handshake chain (bubble-squeezing stall)
  logic adv_a, adv_b, adv_c, adv_d;
  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic u1_rdy, u1_vld, u2_rdy, u2_vld;

  assign adv_d = !d_v_q || frame_o.ready;
  assign adv_c = !c_v_q || u2_rdy;
  assign adv_b = !b_v_q || adv_c;
  assign adv_a = !a_v_q || u1_rdy;
  assign norm_i.ready = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (adv_a) a_v_q <= norm_i.valid;
      if (adv_b) b_v_q <= u1_vld;
      if (adv_c) c_v_q <= b_v_q;
      if (adv_d) d_v_q <= u2_vld;
    end
  end

  // ---- stage A: axis choice and n x axis (only selects and negations)
  logic [2:0][W-1:0]   n_w;
  logic [2:0][W-1:0]   m_w;
  logic [2:0][VW1-1:0] e_w, cy_w;
  ofn_pkg::axis_e      axis_w;
  logic [2:0][W-1:0]   a_n_q;
  logic [2:0][VW1-1:0] a_cy_q;

  assign n_w = {norm_i.normal_z, norm_i.normal_y, norm_i.normal_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_w[i] = n_w[i][W-1] ? (~n_w[i] + W'(1)) : n_w[i];
      e_w[i] = {n_w[i][W-1], n_w[i]};
    end
    if (m_w[0] <= m_w[1] && m_w[0] <= m_w[2]) axis_w = ofn_pkg::AXIS_X;
    else if (m_w[1] <= m_w[2])                 axis_w = ofn_pkg::AXIS_Y;
    else                                       axis_w = ofn_pkg::AXIS_Z;
    unique case (axis_w)
      ofn_pkg::AXIS_X: cy_w = {-e_w[1], e_w[2], VW1'(0)};
      ofn_pkg::AXIS_Y: cy_w = {e_w[0], VW1'(0), -e_w[2]};
      ofn_pkg::AXIS_Z: cy_w = {VW1'(0), -e_w[0], e_w[1]};
      default:         cy_w = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_n_q  <= n_w;
      a_cy_q <= cy_w;
    end
  end

  // ---- first normalizer: y axis
  logic [2:0][F:0]      u1_quo;
  ofn_pkg::unit_flags_t u1_flags;
  logic [SD1-1:0]       u1_side;

  ofn_unit #(.VW(VW1), .FB(F), .SIDEW(SD1)) u_norm_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_v_q),
    .ready_o (u1_rdy),
    .vec_i   (a_cy_q),
    .side_i  (a_n_q),
    .valid_o (u1_vld),
    .ready_i (adv_b),
    .quo_o   (u1_quo),
    .flags_o (u1_flags),
    .side_o  (u1_side)
  );

  // ---- stage B: signed y axis and the six products of y x n
  logic signed [W-1:0]   y_s [3];
  logic signed [W-1:0]   n_s [3];
  logic signed [2*W-1:0] p_w [6];
  logic signed [2*W-1:0] b_p_q [6];
  logic [2:0][W-1:0]     b_y_q, b_n_q;
  logic                  b_deg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y_s[i] = u1_flags.neg[i] ? -$signed(W'(u1_quo[i])) : $signed(W'(u1_quo[i]));
      n_s[i] = $signed(u1_side[i*W +: W]);
    end
    p_w[0] = y_s[1] * n_s[2];
    p_w[1] = y_s[2] * n_s[1];
    p_w[2] = y_s[2] * n_s[0];
    p_w[3] = y_s[0] * n_s[2];
    p_w[4] = y_s[0] * n_s[1];
    p_w[5] = y_s[1] * n_s[0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      b_p_q <= p_w;
      for (int i = 0; i < 3; i++) begin
        b_y_q[i] <= y_s[i];
      end
      b_n_q   <= u1_side;
      b_deg_q <= u1_flags.zero;
    end
  end

  // ---- stage C: y x n
  logic [2:0][VW2-1:0] c_cx_q;
  logic [SD2-1:0]      c_side_q;

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      c_cx_q[0] <= b_p_q[0] - b_p_q[1];
      c_cx_q[1] <= b_p_q[2] - b_p_q[3];
      c_cx_q[2] <= b_p_q[4] - b_p_q[5];
      c_side_q  <= {b_deg_q, b_y_q, b_n_q};
    end
  end

  // ---- second normalizer: x axis
  logic [2:0][F:0]      u2_quo;
  ofn_pkg::unit_flags_t u2_flags;
  logic [SD2-1:0]       u2_side;

  ofn_unit #(.VW(VW2), .FB(F), .SIDEW(SD2)) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v_q),
    .ready_o (u2_rdy),
    .vec_i   (c_cx_q),
    .side_i  (c_side_q),
    .valid_o (u2_vld),
    .ready_i (adv_d),
    .quo_o   (u2_quo),
    .flags_o (u2_flags),
    .side_o  (u2_side)
  );

  // ---- stage D: output register
  // Each term of x.(y x n) pairs a unit component with the aligned component
  // of the same sign, so the triple product is positive exactly when some
  // x quotient is nonzero.
  logic [2:0][W-1:0] x_w, yv_w, xf_w, yf_w;
  logic              deg_w, swap_w;
  logic [2:0][W-1:0] d_x_q, d_y_q, d_z_q;
  logic              d_swap_q, d_deg_q;

  always_comb begin
    deg_w  = u2_side[SD2-1] || u2_flags.zero;
    swap_w = deg_w || ((u2_quo[0] == '0) && (u2_quo[1] == '0) && (u2_quo[2] == '0));
    for (int i = 0; i < 3; i++) begin
      x_w[i]  = u2_flags.neg[i] ? (~W'(u2_quo[i]) + W'(1)) : W'(u2_quo[i]);
      yv_w[i] = u2_side[3*W + i*W +: W];
      xf_w[i] = deg_w ? '0 : x_w[i];
      yf_w[i] = deg_w ? '0 : yv_w[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_d) begin
      d_x_q    <= swap_w ? yf_w : xf_w;
      d_y_q    <= swap_w ? xf_w : yf_w;
      d_z_q    <= u2_side[3*W-1:0];
      d_swap_q <= swap_w;
      d_deg_q  <= deg_w;
    end
  end

  assign frame_o.valid        = d_v_q;
  assign frame_o.xaxis_x      = d_x_q[0];
  assign frame_o.xaxis_y      = d_x_q[1];
  assign frame_o.xaxis_z      = d_x_q[2];
  assign frame_o.yaxis_x      = d_y_q[0];
  assign frame_o.yaxis_y      = d_y_q[1];
  assign frame_o.yaxis_z      = d_y_q[2];
  assign frame_o.zaxis_x      = d_z_q[0];
  assign frame_o.zaxis_y      = d_z_q[1];
  assign frame_o.zaxis_z      = d_z_q[2];
  assign frame_o.axes_swapped = d_swap_q;
  assign frame_o.degenerate   = d_deg_q;

  // ---- checks
  a_deg_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && frame_o.degenerate |-> frame_o.axes_swapped)
    else $error("degenerate frame not flagged as swapped");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && frame_o.degenerate |->
      (d_x_q == '0) && (d_y_q == '0))
    else $error("degenerate frame with nonzero axes");

  a_ok_noswap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && !frame_o.degenerate |-> !frame_o.axes_swapped)
    else $error("regular frame flagged as swapped");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !norm_i.ready |-> frame_o.valid && !frame_o.ready)
    else $error("input stalled while output is free");

endmodule

// File: bench/orthonormal_frame_from_normal_test.sv
// Self-checking bench for orthonormal_frame_from_normal: directed table plus random normals.
// Depends on ofn_pkg, ofn_in_if, ofn_out_if and the DUT; predicts each frame in SV.
module orthonormal_frame_from_normal_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = 16;
  localparam int FRAC       = CW - 2;
  localparam int N_RANDOM   = 630;
  localparam int HOLD_LEN   = 400;   // long receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 200;   // extra wait after the last frame is checked
  localparam int IDLE_LIMIT = 5000;  // watchdog: cycles with no beat moved
  localparam longint CMAX   = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN   = -CMAX - 1;

  // One frame: x axis, y axis, z axis components in order, then the flags.
  typedef struct {
    logic signed [CW-1:0] c[9];
    logic                 swapped;
    logic                 degen;
  } frame_t;

  // Directed row; has_exp marks a frame typed in by hand.
  typedef struct {
    logic signed [CW-1:0] n[3];
    bit                   has_exp;
    frame_t               exp_f;
  } vec_row_t;

  logic clk;
  logic rst_n;
  ofn_in_if  #(.COMPONENT_WIDTH(CW)) norm_if ();
  ofn_out_if #(.COMPONENT_WIDTH(CW)) frame_if ();

  orthonormal_frame_from_normal #(.COMPONENT_WIDTH(CW)) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .norm_i (norm_if),
    .frame_o(frame_if)
  );

  frame_t pending_frames[$];
  int     n_errors = 0;
  bit     hold_req = 0;   // sender asks the receiver for one long hold-off
  string  comp_name[9] = '{"xaxis_x", "xaxis_y", "xaxis_z", "yaxis_x", "yaxis_y",
                           "yaxis_z", "zaxis_x", "zaxis_y", "zaxis_z"};

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // 32-step restoring square root, floor result.
  function automatic longint unsigned sqrt_floor(input longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (s >= res + b) begin
        s   = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Unit vector in Q(FRAC); sc gets the signed components after the
  // alignment shift. Returns 0 for a zero vector.
  function automatic bit normalize(input longint v[3], output longint u[3],
                                   output longint sc[3]);
    longint unsigned mag[3];
    longint unsigned a[3];
    longint unsigned mx, sum, len, q;
    longint          r;
    int              sh;
    mx  = 0;
    sum = 0;
    sh  = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    // bring every magnitude below 2^31 before squaring
    while (sh < 63 && (mx >> sh) >= (64'd1 << 31)) sh++;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag[i] >> sh;
      sum  = sum + a[i] * a[i];
    end
    len = sqrt_floor(sum);
    for (int i = 0; i < 3; i++) begin
      u[i]  = 0;
      sc[i] = (v[i] < 0) ? -longint'(a[i]) : longint'(a[i]);
    end
    if (len == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      // round half away from zero, sign reapplied afterwards
      q = ((a[i] << (FRAC + 1)) + len) / (2 * len);
      r = (v[i] < 0) ? -longint'(q) : longint'(q);
      if (r > CMAX) r = CMAX;
      if (r < CMIN) r = CMIN;
      u[i] = r;
    end
    return 1;
  endfunction

  function automatic frame_t predict_frame(input logic signed [CW-1:0] nv[3]);
    frame_t          f;
    longint          n[3], ax[3], cy[3], cx[3], yv[3], xv[3], sy[3], sx[3];
    longint unsigned m[3];
    longint          triple;
    ofn_pkg::axis_e  pick;
    bit              ok;
    for (int i = 0; i < 3; i++) begin
      n[i]  = nv[i];
      m[i]  = (n[i] < 0) ? -n[i] : n[i];
      ax[i] = 0;
    end
    // smallest |component|, ties to x then y
    if (m[0] <= m[1] && m[0] <= m[2]) pick = ofn_pkg::AXIS_X;
    else if (m[1] <= m[2])            pick = ofn_pkg::AXIS_Y;
    else                              pick = ofn_pkg::AXIS_Z;
    case (pick)
      ofn_pkg::AXIS_X: ax[0] = 1;
      ofn_pkg::AXIS_Y: ax[1] = 1;
      default:         ax[2] = 1;
    endcase
    cross_prod(n, ax, cy);
    ok = normalize(cy, yv, sy);
    if (ok) begin
      cross_prod(yv, n, cx);
      ok = normalize(cx, xv, sx);
    end
    if (!ok) begin
      for (int i = 0; i < 3; i++) begin
        xv[i] = 0;
        yv[i] = 0;
        sx[i] = 0;
      end
    end
    triple    = xv[0] * sx[0] + xv[1] * sx[1] + xv[2] * sx[2];
    f.swapped = !(triple > 0);
    f.degen   = !ok;
    for (int i = 0; i < 3; i++) begin
      f.c[i]     = CW'(f.swapped ? yv[i] : xv[i]);
      f.c[3 + i] = CW'(f.swapped ? xv[i] : yv[i]);
      f.c[6 + i] = nv[i];
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed stimulus table
  // ---------------------------------------------------------------------------

  function automatic vec_row_t mk_row(input int x, input int y, input int z);
    vec_row_t r;
    r.n[0]    = CW'(x);
    r.n[1]    = CW'(y);
    r.n[2]    = CW'(z);
    r.has_exp = 0;
    r.exp_f   = predict_frame(r.n);
    return r;
  endfunction

  function automatic vec_row_t mk_fixed(input int x, input int y, input int z,
                                        input int ex[6], input bit sw, input bit dg);
    vec_row_t r;
    r = mk_row(x, y, z);
    r.has_exp = 1;
    for (int i = 0; i < 6; i++) r.exp_f.c[i] = CW'(ex[i]);
    r.exp_f.c[6]    = CW'(x);
    r.exp_f.c[7]    = CW'(y);
    r.exp_f.c[8]    = CW'(z);
    r.exp_f.swapped = sw;
    r.exp_f.degen   = dg;
    return r;
  endfunction

  vec_row_t dir_rows[$];

  task automatic build_table();
    // zero normal: degenerate, zero axes, swap flag from a zero triple product
    dir_rows.push_back(mk_fixed(0, 0, 0, '{0, 0, 0, 0, 0, 0}, 1, 1));
    // +x normal: x axis = +y, y axis = +z
    dir_rows.push_back(mk_fixed(16384, 0, 0, '{0, 16384, 0, 0, 0, 16384}, 0, 0));
    dir_rows.push_back(mk_row(0, 16384, 0));
    dir_rows.push_back(mk_row(0, 0, 16384));
    dir_rows.push_back(mk_row(-16384, 0, 0));
    dir_rows.push_back(mk_row(0, -16384, 0));
    dir_rows.push_back(mk_row(0, 0, -16384));
    dir_rows.push_back(mk_row(-32768, -32768, -32768));
    dir_rows.push_back(mk_row(32767, 32767, 32767));
    dir_rows.push_back(mk_row(-32768, 32767, 0));
    dir_rows.push_back(mk_row(-32768, 0, 0));
    dir_rows.push_back(mk_row(32767, -32768, 32767));
    // ties on the smallest component
    dir_rows.push_back(mk_row(1, 1, 1));
    dir_rows.push_back(mk_row(5, 5, -7));
    dir_rows.push_back(mk_row(9, -3, 3));
    // non-unit normals, tiny and odd patterns
    dir_rows.push_back(mk_row(1, 0, 0));
    dir_rows.push_back(mk_row(-1, -1, -1));
    dir_rows.push_back(mk_row(0, 0, 1));
    dir_rows.push_back(mk_row(16'sh5555, -16'sh2AAA, 16'sh1234));
    dir_rows.push_back(mk_row(9459, 9459, 9459));
    dir_rows.push_back(mk_row(11585, -11585, 0));
    dir_rows.push_back(mk_row(-21846, 10923, -5462));
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one beat, held until accepted
  // ---------------------------------------------------------------------------

  task automatic send_normal(input logic signed [CW-1:0] nv[3], input frame_t ef);
    norm_if.valid    <= 1'b1;
    norm_if.normal_x <= nv[0];
    norm_if.normal_y <= nv[1];
    norm_if.normal_z <= nv[2];
    @(posedge clk);
    while (!norm_if.ready) @(posedge clk);
    pending_frames.push_back(ef);
  endtask

  task automatic idle_gap(input int cycles);
    norm_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly unit-scale directions; some full-range, tiny and axis-near ones.
  function automatic void rand_normal(output logic signed [CW-1:0] nv[3]);
    int mode, dom;
    mode = $urandom_range(0, 9);
    dom  = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      if (mode < 6)       nv[i] = CW'($urandom_range(0, 32768) - 16384);
      else if (mode < 8)  nv[i] = CW'($urandom());
      else if (mode == 8) nv[i] = CW'($urandom_range(0, 8) - 4);
      else                nv[i] = CW'((i == dom) ? ($urandom_range(0, 1) ? 16384 : -16384)
                                                 : ($urandom_range(0, 64) - 32));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, stall-free stretches, one long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    frame_if.ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        frame_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end
      // phase 0: free flowing; phase 1: random stalls; phase 2: mostly stalled
      if ($urandom_range(0, 63) == 0) phase = $urandom_range(0, 2);
      case (phase)
        0:       frame_if.ready <= 1'b1;
        1:       frame_if.ready <= ($urandom_range(0, 3) != 0);
        default: frame_if.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    frame_t ef;
    frame_t got;
    if (rst_n && frame_if.valid && frame_if.ready) begin
      got.c[0]    = frame_if.xaxis_x;
      got.c[1]    = frame_if.xaxis_y;
      got.c[2]    = frame_if.xaxis_z;
      got.c[3]    = frame_if.yaxis_x;
      got.c[4]    = frame_if.yaxis_y;
      got.c[5]    = frame_if.yaxis_z;
      got.c[6]    = frame_if.zaxis_x;
      got.c[7]    = frame_if.zaxis_y;
      got.c[8]    = frame_if.zaxis_z;
      got.swapped = frame_if.axes_swapped;
      got.degen   = frame_if.degenerate;
      if (pending_frames.size() == 0) begin
        $error("frame beat with no normal outstanding");
        n_errors++;
      end else begin
        ef = pending_frames.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got.c[i] !== ef.c[i]) begin
            $error("%s: expected %0d, got %0d", comp_name[i], ef.c[i], got.c[i]);
            n_errors++;
          end
        end
        if (got.swapped !== ef.swapped) begin
          $error("axes_swapped: expected %0b, got %0b", ef.swapped, got.swapped);
          n_errors++;
        end
        if (got.degen !== ef.degen) begin
          $error("degenerate: expected %0b, got %0b", ef.degen, got.degen);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((norm_if.valid && norm_if.ready) || (frame_if.valid && frame_if.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic signed [CW-1:0] nv[3];
    int                   burst;
    rst_n            = 1'b0;
    norm_if.valid    = 1'b0;
    norm_if.normal_x = '0;
    norm_if.normal_y = '0;
    norm_if.normal_z = '0;
    build_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, back to back
    foreach (dir_rows[k]) send_normal(dir_rows[k].n, dir_rows[k].exp_f);
    idle_gap($urandom_range(1, 5));

    // random part: bursts with gaps
    burst = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      // fill the pipe against a stalled output
      if (k == 150) hold_req = 1;
      // drain completely once before going on
      if (k == 350) begin
        norm_if.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      rand_normal(nv);
      send_normal(nv, predict_frame(nv));
      burst--;
    end
    norm_if.valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ofn_pkg.sv
sv/ofn_in_if.sv
sv/ofn_out_if.sv
sv/ofn_unit.sv
sv/orthonormal_frame_from_normal.sv
bench/orthonormal_frame_from_normal_test.sv
